// ===== hw/rtl/mst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants of the minimum spanning tree core.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int VERTICES    = 8;
  localparam int WEIGHT_BITS = 16;

  localparam int VTX_W   = 3;
  localparam int COST_W  = 16;
  localparam int TOTAL_W = 19;

  localparam int VIDX_W = $clog2(VERTICES);
  localparam int DEPTH  = VERTICES * VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [WEIGHT_BITS-1:0] NO_EDGE   = {WEIGHT_BITS{1'b1}};
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RUN   = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [VTX_W-1:0]  row;
    logic [VTX_W-1:0]  col;
    logic [COST_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]   edge_from;
    logic [VTX_W-1:0]   edge_to;
    logic [COST_W-1:0]  edge_cost;
    logic [TOTAL_W-1:0] total_cost;
    logic               disconnected;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_SEED_END,
    ST_E_RD,
    ST_E_CAP,
    ST_E_OUT,
    ST_STREAM,
    ST_DRAIN,
    ST_APPLY,
    ST_SELECT,
    ST_SEL_DONE
  } state_e;

  typedef struct packed {
    logic                   clear;
    logic                   mark_a;
    logic [VIDX_W-1:0]      mark_a_idx;
    logic                   mark_b;
    logic [VIDX_W-1:0]      mark_b_idx;
    logic                   shift;
    logic                   apply;
    logic                   apply_init;
    logic [VIDX_W-1:0]      col;
  } cell_ctrl_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] best;
    logic [VIDX_W-1:0]      k;
    logic [VIDX_W-1:0]      kn;
    logic                   found;
    logic [VIDX_W-1:0]      fk;
    logic [VIDX_W-1:0]      fkn;
    logic                   fvalid;
  } sel_tok_t;

  function automatic logic [ADDR_W-1:0] cost_addr(logic [VIDX_W-1:0] r,
                                                  logic [VIDX_W-1:0] c);
    cost_addr = ADDR_W'(int'(r) * VERTICES + int'(c));
  endfunction

endpackage

// ===== hw/rtl/prim_minimum_spanning_tree_core.sv =====
`timescale 1ns / 1ps
// Write beat: no result. Run beat: the seed scan reads the lower triangle, and
// the first edge follows through the seed end, edge read, capture and output
// states. Each further edge needs a column stream of V reads and a search of V
// chain stages; the seed edge adds one more column stream. One cost store read
// port sets the pace. Reset: all control state clears, and every cost entry
// reads as no edge through per-entry valid flags.
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// Minimum spanning tree on a loaded adjacency cost matrix, emitted edge by edge.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mst_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mst_pkg::out_item_t  out_data_o
);
  import mst_pkg::*;

  localparam logic [VIDX_W-1:0] LAST_IDX  = VIDX_W'(VERTICES - 1);
  localparam logic [VIDX_W-1:0] LAST_EDGE = VIDX_W'(VERTICES - 2);

  state_e                 state_q, state_d;
  logic [VIDX_W-1:0]      cnt_q, cnt_d;
  logic [VIDX_W-1:0]      si_q, si_d, sj_q, sj_d;
  logic                   seed_pend_q, seed_pend_d;
  logic [VIDX_W-1:0]      pi_q, pi_d, pj_q, pj_d;
  logic [WEIGHT_BITS-1:0] best_q, best_d;
  logic [VIDX_W-1:0]      u_q, u_d, v_q, v_d;
  logic [VIDX_W-1:0]      from_q, from_d, to_q, to_d;
  logic [WEIGHT_BITS-1:0] ecost_q, ecost_d;
  logic [TOTAL_W-1:0]     total_q, total_d;
  logic                   disc_q, disc_d;
  logic [VIDX_W-1:0]      edge_cnt_q, edge_cnt_d;
  logic [VIDX_W-1:0]      col_q, col_d;
  logic                   init_q, init_d;
  logic                   str_pend_q, str_pend_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  logic                   in_acc;
  logic                   wr_en;
  logic                   rd_en;
  logic [VIDX_W-1:0]      rd_row, rd_col;
  logic [WEIGHT_BITS-1:0] rcost;
  logic                   seed_take;
  logic [VIDX_W-1:0]      u_new, v_new;
  logic                   slot_free;
  logic                   emit;
  logic                   emit_last;
  logic [TOTAL_W:0]       sum;
  logic [TOTAL_W-1:0]     total_new;
  logic [VIDX_W-1:0]      pick_k, pick_from;
  cell_ctrl_t             ctrl;

  logic [WEIGHT_BITS-1:0] sh_w   [VERTICES];
  sel_tok_t               tok_w  [VERTICES];
  logic [VERTICES-1:0]    in_tree_w;
  sel_tok_t               tok_seed;
  sel_tok_t               tok_end;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && (in_data_i.op == OP_WRITE) &&
                      (int'(in_data_i.row) < VERTICES) && (int'(in_data_i.col) < VERTICES);

  mst_cost_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (cost_addr(VIDX_W'(in_data_i.row), VIDX_W'(in_data_i.col))),
    .wr_data_i (WEIGHT_BITS'(in_data_i.weight)),
    .rd_en_i   (rd_en),
    .rd_addr_i (cost_addr(rd_row, rd_col)),
    .rd_data_o (rcost)
  );

  assign tok_seed = '{best: NO_EDGE, default: '0};

  for (genvar g = 0; g < VERTICES; g++) begin : g_cell
    mst_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (VIDX_W'(g)),
      .ctrl_i    (ctrl),
      .sh_i      ((g == 0) ? rcost : sh_w[(g == 0) ? 0 : g - 1]),
      .sh_o      (sh_w[g]),
      .tok_i     ((g == 0) ? tok_seed : tok_w[(g == 0) ? 0 : g - 1]),
      .tok_o     (tok_w[g]),
      .in_tree_o (in_tree_w[g])
    );
  end

  assign tok_end   = tok_w[VERTICES-1];
  assign pick_k    = tok_end.found ? tok_end.k  : tok_end.fk;
  assign pick_from = tok_end.found ? tok_end.kn : tok_end.fkn;

  assign seed_take = seed_pend_q && (rcost < best_q);
  assign u_new     = seed_take ? pi_q : u_q;
  assign v_new     = seed_take ? pj_q : v_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == ST_E_OUT) && slot_free;
  assign emit_last = (edge_cnt_q == LAST_EDGE);

  assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(ecost_q);
  assign total_new = (ecost_q == NO_EDGE) ? TOTAL_MAX :
                     (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    si_d        = si_q;
    sj_d        = sj_q;
    seed_pend_d = (state_q == ST_SEED);
    pi_d        = si_q;
    pj_d        = sj_q;
    best_d      = seed_take ? rcost : best_q;
    u_d         = u_new;
    v_d         = v_new;
    from_d      = from_q;
    to_d        = to_q;
    ecost_d     = ecost_q;
    total_d     = total_q;
    disc_d      = disc_q;
    edge_cnt_d  = edge_cnt_q;
    col_d       = col_q;
    init_d      = init_q;
    str_pend_d  = (state_q == ST_STREAM);
    rd_en       = 1'b0;
    rd_row      = si_q;
    rd_col      = sj_q;
    ctrl        = '0;
    ctrl.shift  = str_pend_q;
    ctrl.col    = col_q;
    ctrl.apply_init = init_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.op == OP_RUN) begin
          best_d     = NO_EDGE;
          u_d        = VIDX_W'(1);
          v_d        = '0;
          si_d       = VIDX_W'(1);
          sj_d       = '0;
          total_d    = '0;
          disc_d     = 1'b0;
          edge_cnt_d = '0;
          ctrl.clear = 1'b1;
          state_d    = ST_SEED;
        end
      end
      ST_SEED: begin
        rd_en = 1'b1;
        if (sj_q == si_q - VIDX_W'(1)) begin
          sj_d = '0;
          if (si_q == LAST_IDX) begin
            state_d = ST_SEED_END;
          end else begin
            si_d = si_q + VIDX_W'(1);
          end
        end else begin
          sj_d = sj_q + VIDX_W'(1);
        end
      end
      ST_SEED_END: begin
        from_d          = u_new;
        to_d            = v_new;
        ctrl.mark_a     = 1'b1;
        ctrl.mark_a_idx = u_new;
        ctrl.mark_b     = 1'b1;
        ctrl.mark_b_idx = v_new;
        state_d         = ST_E_RD;
      end
      ST_E_RD: begin
        rd_en   = 1'b1;
        rd_row  = from_q;
        rd_col  = to_q;
        state_d = ST_E_CAP;
      end
      ST_E_CAP: begin
        ecost_d = rcost;
        state_d = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (slot_free) begin
          total_d    = total_new;
          disc_d     = disc_q || (ecost_q == NO_EDGE);
          edge_cnt_d = edge_cnt_q + VIDX_W'(1);
          cnt_d      = '0;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (edge_cnt_q == '0) begin
            col_d   = u_q;
            init_d  = 1'b1;
            state_d = ST_STREAM;
          end else begin
            col_d   = to_q;
            init_d  = 1'b0;
            state_d = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        rd_en  = 1'b1;
        rd_row = LAST_IDX - cnt_q;
        rd_col = col_q;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + VIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        ctrl.apply = 1'b1;
        cnt_d      = '0;
        if (init_q) begin
          col_d   = v_q;
          init_d  = 1'b0;
          state_d = ST_STREAM;
        end else begin
          state_d = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_SEL_DONE;
        end else begin
          cnt_d = cnt_q + VIDX_W'(1);
        end
      end
      ST_SEL_DONE: begin
        to_d            = pick_k;
        from_d          = pick_from;
        ctrl.mark_a     = 1'b1;
        ctrl.mark_a_idx = pick_k;
        state_d         = ST_E_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d             = 1'b1;
      out_data_d.edge_from    = VTX_W'(from_q);
      out_data_d.edge_to      = VTX_W'(to_q);
      out_data_d.edge_cost    = COST_W'(ecost_q);
      out_data_d.total_cost   = total_new;
      out_data_d.disconnected = disc_q || (ecost_q == NO_EDGE);
      out_data_d.last         = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      si_q        <= '0;
      sj_q        <= '0;
      seed_pend_q <= 1'b0;
      edge_cnt_q  <= '0;
      init_q      <= 1'b0;
      str_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      si_q        <= si_d;
      sj_q        <= sj_d;
      seed_pend_q <= seed_pend_d;
      edge_cnt_q  <= edge_cnt_d;
      init_q      <= init_d;
      str_pend_q  <= str_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q       <= pi_d;
    pj_q       <= pj_d;
    best_q     <= best_d;
    u_q        <= u_d;
    v_q        <= v_d;
    from_q     <= from_d;
    to_q       <= to_d;
    ecost_q    <= ecost_d;
    total_q    <= total_d;
    disc_q     <= disc_d;
    col_q      <= col_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_disc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disconnected |-> out_data_o.total_cost == TOTAL_MAX)
    else $error("disconnected beat without saturated total");

  a_tree_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_OUT |-> $countones(in_tree_w) == int'(edge_cnt_q) + 2)
    else $error("tree size does not match edge count");

  a_pick_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEL_DONE |-> !in_tree_w[pick_k])
    else $error("selected vertex already in tree");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_last |=> state_q == ST_IDLE)
    else $error("run did not end after last edge");

endmodule

// ===== hw/rtl/mst_cost_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_cost_mem
// Adjacency cost store: one write and one registered read per cycle.
// Entries never written read as no edge.
// ----------------------------------------------------------------------------
module mst_cost_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [mst_pkg::ADDR_W-1:0]      wr_addr_i,
  input  logic [mst_pkg::WEIGHT_BITS-1:0] wr_data_i,
  input  logic                            rd_en_i,
  input  logic [mst_pkg::ADDR_W-1:0]      rd_addr_i,
  output logic [mst_pkg::WEIGHT_BITS-1:0] rd_data_o
);
  import mst_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld_q;
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : NO_EDGE;

endmodule

// ===== hw/rtl/mst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_cell
// One vertex of the chain: tree flag, nearest tree vertex and its cost, a
// column shift stage and a registered stage of the minimum search.
// ----------------------------------------------------------------------------
module mst_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mst_pkg::VIDX_W-1:0]      idx_i,
  input  mst_pkg::cell_ctrl_t             ctrl_i,
  input  logic [mst_pkg::WEIGHT_BITS-1:0] sh_i,
  output logic [mst_pkg::WEIGHT_BITS-1:0] sh_o,
  input  mst_pkg::sel_tok_t               tok_i,
  output mst_pkg::sel_tok_t               tok_o,
  output logic                            in_tree_o
);
  import mst_pkg::*;

  logic                   in_tree_q, in_tree_d;
  logic [VIDX_W-1:0]      near_q, near_d;
  logic [WEIGHT_BITS-1:0] key_q, key_d;
  logic [WEIGHT_BITS-1:0] sh_q, sh_d;
  sel_tok_t               tok_q, tok_d;

  always_comb begin
    logic cand;
    in_tree_d = in_tree_q;
    near_d    = near_q;
    key_d     = key_q;
    sh_d      = ctrl_i.shift ? sh_i : sh_q;
    if (ctrl_i.clear) begin
      in_tree_d = 1'b0;
    end
    if ((ctrl_i.mark_a && ctrl_i.mark_a_idx == idx_i) ||
        (ctrl_i.mark_b && ctrl_i.mark_b_idx == idx_i)) begin
      in_tree_d = 1'b1;
    end
    if (ctrl_i.apply) begin
      if (ctrl_i.apply_init || (!in_tree_q && key_q > sh_q)) begin
        near_d = ctrl_i.col;
        key_d  = sh_q;
      end
    end

    // search stage: first strict minimum, plus first free vertex
    tok_d = tok_i;
    cand  = !in_tree_q && (key_q < tok_i.best);
    if (cand) begin
      tok_d.best  = key_q;
      tok_d.k     = idx_i;
      tok_d.kn    = near_q;
      tok_d.found = 1'b1;
    end
    if (!in_tree_q && !tok_i.fvalid) begin
      tok_d.fk     = idx_i;
      tok_d.fkn    = near_q;
      tok_d.fvalid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tree_q <= 1'b0;
      near_q    <= '0;
      tok_q     <= '0;
    end else begin
      in_tree_q <= in_tree_d;
      near_q    <= near_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sh_q  <= sh_d;
  end

  assign sh_o      = sh_q;
  assign tok_o     = tok_q;
  assign in_tree_o = in_tree_q;

endmodule
